### hdl/ppp_pkg.sv
`timescale 1ns / 1ps

package ppp_pkg;

    // Default width of the skip counter for length-delimited bodies.
    localparam int LENGTH_BITS_DEF = 16;

    localparam int FIELD_BITS = 29;
    localparam int ACC_BITS   = 32;
    localparam int CNT_BITS   = 4;

    // Protobuf wire types.
    localparam logic [2:0] WT_VARINT  = 3'd0;
    localparam logic [2:0] WT_FIXED64 = 3'd1;
    localparam logic [2:0] WT_LENGTH  = 3'd2;
    localparam logic [2:0] WT_FIXED32 = 3'd5;

    // Field numbers of interest.
    localparam logic [FIELD_BITS-1:0] FLD_LATITUDE   = 29'd1;
    localparam logic [FIELD_BITS-1:0] FLD_LONGITUDE  = 29'd2;
    localparam logic [FIELD_BITS-1:0] FLD_ALTITUDE   = 29'd3;
    localparam logic [FIELD_BITS-1:0] FLD_TIME       = 29'd4;
    localparam logic [FIELD_BITS-1:0] FLD_SATELLITES = 29'd14;

    // Presence mask bits.
    localparam int PM_LAT  = 0;
    localparam int PM_LON  = 1;
    localparam int PM_ALT  = 2;
    localparam int PM_TIME = 3;
    localparam int PM_SATS = 4;

    // Byte limits for varints.
    localparam logic [CNT_BITS-1:0] TAG_MAX_BYTES   = 4'd5;
    localparam logic [CNT_BITS-1:0] VALUE_MAX_BYTES = 4'd10;
    localparam logic [CNT_BITS-1:0] FIXED32_BYTES   = 4'd4;
    localparam int FIXED64_BYTES = 8;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_LAT    = 2'd1,
        ST_MALFORMED = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        PH_TAG     = 3'd0,
        PH_VARINT  = 3'd1,
        PH_LENGTH  = 3'd2,
        PH_SKIP    = 3'd3,
        PH_FIXED   = 3'd4,
        PH_DISCARD = 3'd5
    } t_phase;

    typedef struct packed {
        logic [7:0] message_byte;
        logic       final_byte;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] latitude;
        logic signed [31:0] longitude;
        logic signed [31:0] altitude;
        logic        [31:0] fix_time;
        logic        [31:0] satellites;
        logic        [4:0]  present_mask;
        logic        [1:0]  parse_status;
    } t_out_word;

    typedef struct packed {
        t_phase                phase;
        logic [FIELD_BITS-1:0] field;
        logic                  fixed64;
        logic                  malf;
    } t_tag_info;

    // Split a decoded tag into field number and the phase for its value.
    function automatic t_tag_info close_tag(input logic [ACC_BITS-1:0] acc);
        t_tag_info ti;
        ti.field   = acc[31:3];
        ti.fixed64 = 1'b0;
        ti.malf    = 1'b0;
        unique case (acc[2:0])
            WT_VARINT:  ti.phase = PH_VARINT;
            WT_LENGTH:  ti.phase = PH_LENGTH;
            WT_FIXED32: ti.phase = PH_FIXED;
            WT_FIXED64: begin
                ti.phase   = PH_SKIP;
                ti.fixed64 = 1'b1;
            end
            default: begin
                ti.phase = PH_DISCARD;
                ti.malf  = 1'b1;
            end
        endcase
        return ti;
    endfunction

endpackage

### hdl/ppp_stream_if.sv
`timescale 1ns / 1ps

interface ppp_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### hdl/protobuf_position_parser_top.sv
`timescale 1ns / 1ps
// Result: the word for a message is registered and appears on o_fix in the cycle after its final byte is taken.
// Throughput: one byte per cycle; i_msg is ready whenever the result register is empty
// or being drained, so a full o_fix stalls input only while o_fix.ready is low.
// Reset: i_rst_n synchronous, active low; parser state and held fields go to zero,
// the result register is emptied.

module protobuf_position_parser_top
    import ppp_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    ppp_stream_if.sink                     i_msg,
    ppp_stream_if.source                   o_fix
);

    // ---------------------------------------------------------------
    // Parser state
    // ---------------------------------------------------------------
    t_phase                  r_phase,  n_phase;
    logic [ACC_BITS-1:0]     r_acc,    n_acc;    // ACC_BITS = 32 wide; groups shifted past bit 31 are lost
    logic [CNT_BITS-1:0]     r_cnt,    n_cnt;
    logic [FIELD_BITS-1:0]   r_field,  n_field;
    logic [LENGTH_BITS-1:0]  r_skip,   n_skip;
    logic [31:0]             r_lat,    n_lat;
    logic [31:0]             r_lon,    n_lon;
    logic [31:0]             r_alt,    n_alt;
    logic [31:0]             r_time,   n_time;
    logic [31:0]             r_sats,   n_sats;
    logic [4:0]              r_mask,   n_mask;
    logic                    r_malf,   n_malf;

    // Result register
    t_out_word               r_out,    n_out;
    logic                    r_out_vld, n_out_vld;

    t_in_word                in_w;
    logic                    in_acc;
    logic [6:0]              low7;
    logic                    more;
    logic [5:0]              shamt7;
    logic [ACC_BITS-1:0]     acc_var;     // accumulator with a 7-bit group merged in
    logic [ACC_BITS-1:0]     acc_fix;     // accumulator with a raw byte merged in
    logic [CNT_BITS-1:0]     cnt_inc;
    logic [LENGTH_BITS-1:0]  skip_dec;
    logic                    len_big;
    t_tag_info               tag_take;
    t_tag_info               tag_fin;

    // Values after the byte is taken
    t_phase                  tk_phase;
    logic [ACC_BITS-1:0]     tk_acc;
    logic [CNT_BITS-1:0]     tk_cnt;
    logic [FIELD_BITS-1:0]   tk_field;
    logic [LENGTH_BITS-1:0]  tk_skip;
    logic [31:0]             tk_lat, tk_lon, tk_alt, tk_time, tk_sats;
    logic [4:0]              tk_mask;
    logic                    tk_malf;

    // Values after the message is settled on its final byte
    t_phase                  fn_phase;
    logic [ACC_BITS-1:0]     fn_acc;
    logic [FIELD_BITS-1:0]   fn_field;
    logic [31:0]             fn_alt, fn_sats;
    logic [4:0]              fn_mask;
    logic                    fn_malf;
    t_out_word               res_w;

    // ---------------------------------------------------------------
    // Handshake: the result register parts the two sides, so a new
    // byte is taken while the last result is being drained.
    // ---------------------------------------------------------------
    assign in_w        = i_msg.payload;
    assign i_msg.ready = !r_out_vld || o_fix.ready;
    assign in_acc      = i_msg.valid && i_msg.ready;
    assign o_fix.valid   = r_out_vld;
    assign o_fix.payload = r_out;

    // ---------------------------------------------------------------
    // Byte-level decode shared by the phases
    // ---------------------------------------------------------------
    assign low7     = in_w.message_byte[6:0];
    assign more     = in_w.message_byte[7];
    assign shamt7   = 6'(7'(r_cnt) * 7'd7);     // at most 9 * 7 = 63 in the varint phases
    assign acc_var  = r_acc | (ACC_BITS'(low7) << shamt7);
    assign acc_fix  = r_acc | (ACC_BITS'(in_w.message_byte) << {r_cnt[1:0], 3'b000});
    assign cnt_inc  = r_cnt + 1'b1;
    assign skip_dec = (r_skip != '0) ? r_skip - 1'b1 : r_skip;
    assign len_big  = (acc_var >> LENGTH_BITS) != '0;
    assign tag_take = close_tag(acc_var);

    // ---------------------------------------------------------------
    // Take one byte
    // ---------------------------------------------------------------
    always_comb begin
        tk_phase = r_phase;
        tk_acc   = r_acc;
        tk_cnt   = r_cnt;
        tk_field = r_field;
        tk_skip  = r_skip;
        tk_lat   = r_lat;
        tk_lon   = r_lon;
        tk_alt   = r_alt;
        tk_time  = r_time;
        tk_sats  = r_sats;
        tk_mask  = r_mask;
        tk_malf  = r_malf;
        unique case (r_phase)
            PH_TAG, PH_LENGTH: begin
                tk_acc = acc_var;
                tk_cnt = cnt_inc;
                if (!more) begin
                    if (r_phase == PH_TAG) begin
                        tk_field = tag_take.field;
                        tk_acc   = '0;
                        tk_cnt   = '0;
                        tk_phase = tag_take.phase;
                        tk_malf  = tag_take.malf;
                        if (tag_take.fixed64) begin
                            tk_skip = LENGTH_BITS'(FIXED64_BYTES);
                        end
                    end else if (len_big) begin
                        tk_malf  = 1'b1;
                        tk_phase = PH_DISCARD;
                    end else if (acc_var == '0) begin
                        tk_phase = PH_TAG;
                        tk_acc   = '0;
                        tk_cnt   = '0;
                    end else begin
                        tk_skip  = acc_var[LENGTH_BITS-1:0];
                        tk_phase = PH_SKIP;
                    end
                end else if (cnt_inc >= TAG_MAX_BYTES) begin
                    tk_malf  = 1'b1;
                    tk_phase = PH_DISCARD;
                end
            end
            PH_VARINT: begin
                tk_acc = acc_var;
                tk_cnt = cnt_inc;
                if (!more) begin
                    if (r_field == FLD_ALTITUDE) begin
                        tk_alt          = acc_var;
                        tk_mask[PM_ALT] = 1'b1;
                    end else if (r_field == FLD_SATELLITES) begin
                        tk_sats          = acc_var;
                        tk_mask[PM_SATS] = 1'b1;
                    end
                    tk_phase = PH_TAG;
                    tk_acc   = '0;
                    tk_cnt   = '0;
                end else if (cnt_inc >= VALUE_MAX_BYTES) begin
                    tk_malf  = 1'b1;
                    tk_phase = PH_DISCARD;
                end
            end
            PH_FIXED: begin
                tk_acc = acc_fix;
                tk_cnt = cnt_inc;
                if (cnt_inc >= FIXED32_BYTES) begin
                    if (r_field == FLD_LATITUDE) begin
                        tk_lat          = acc_fix;
                        tk_mask[PM_LAT] = 1'b1;
                    end else if (r_field == FLD_LONGITUDE) begin
                        tk_lon          = acc_fix;
                        tk_mask[PM_LON] = 1'b1;
                    end else if (r_field == FLD_TIME) begin
                        tk_time          = acc_fix;
                        tk_mask[PM_TIME] = 1'b1;
                    end
                    tk_phase = PH_TAG;
                    tk_acc   = '0;
                    tk_cnt   = '0;
                end
            end
            PH_SKIP: begin
                tk_skip = skip_dec;
                if (skip_dec == '0) begin
                    tk_phase = PH_TAG;
                    tk_acc   = '0;
                    tk_cnt   = '0;
                end
            end
            default: ;  // discarding: byte swallowed
        endcase
    end

    // ---------------------------------------------------------------
    // Settle at the final byte: a tag cut short is decoded from its
    // partial bits, then whatever phase is left open is closed out.
    // ---------------------------------------------------------------
    assign tag_fin = close_tag(tk_acc);

    always_comb begin
        fn_phase = tk_phase;
        fn_acc   = tk_acc;
        fn_field = tk_field;
        fn_alt   = tk_alt;
        fn_sats  = tk_sats;
        fn_mask  = tk_mask;
        fn_malf  = tk_malf;
        if (tk_phase == PH_TAG && tk_cnt != '0) begin
            fn_phase = tag_fin.phase;
            fn_field = tag_fin.field;
            fn_acc   = '0;
            fn_malf  = tk_malf | tag_fin.malf;
        end
        case (fn_phase)
            PH_VARINT: begin
                if (fn_field == FLD_ALTITUDE) begin
                    fn_alt          = fn_acc;
                    fn_mask[PM_ALT] = 1'b1;
                end else if (fn_field == FLD_SATELLITES) begin
                    fn_sats          = fn_acc;
                    fn_mask[PM_SATS] = 1'b1;
                end
            end
            PH_LENGTH: begin
                if (fn_acc != '0) begin
                    fn_malf = 1'b1;
                end
            end
            PH_SKIP, PH_FIXED: fn_malf = 1'b1;
            default: ;
        endcase
    end

    // Result word
    always_comb begin
        res_w.latitude     = $signed(tk_lat);
        res_w.longitude    = $signed(tk_lon);
        res_w.altitude     = $signed(fn_alt);
        res_w.fix_time     = tk_time;
        res_w.satellites   = fn_sats;
        res_w.present_mask = fn_mask;
        if (fn_malf) begin
            res_w.parse_status = ST_MALFORMED;
        end else if (!fn_mask[PM_LAT]) begin
            res_w.parse_status = ST_NO_LAT;
        end else begin
            res_w.parse_status = ST_OK;
        end
    end

    // ---------------------------------------------------------------
    // Next state: the final byte clears everything for the next message
    // ---------------------------------------------------------------
    always_comb begin
        n_phase   = r_phase;
        n_acc     = r_acc;
        n_cnt     = r_cnt;
        n_field   = r_field;
        n_skip    = r_skip;
        n_lat     = r_lat;
        n_lon     = r_lon;
        n_alt     = r_alt;
        n_time    = r_time;
        n_sats    = r_sats;
        n_mask    = r_mask;
        n_malf    = r_malf;
        n_out     = r_out;
        n_out_vld = r_out_vld && !o_fix.ready;
        if (in_acc) begin
            if (in_w.final_byte) begin
                n_phase   = PH_TAG;
                n_acc     = '0;
                n_cnt     = '0;
                n_field   = '0;
                n_skip    = '0;
                n_lat     = '0;
                n_lon     = '0;
                n_alt     = '0;
                n_time    = '0;
                n_sats    = '0;
                n_mask    = '0;
                n_malf    = 1'b0;
                n_out     = res_w;
                n_out_vld = 1'b1;
            end else begin
                n_phase = tk_phase;
                n_acc   = tk_acc;
                n_cnt   = tk_cnt;
                n_field = tk_field;
                n_skip  = tk_skip;
                n_lat   = tk_lat;
                n_lon   = tk_lon;
                n_alt   = tk_alt;
                n_time  = tk_time;
                n_sats  = tk_sats;
                n_mask  = tk_mask;
                n_malf  = tk_malf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_TAG;
            r_acc     <= '0;
            r_cnt     <= '0;
            r_field   <= '0;
            r_skip    <= '0;
            r_lat     <= '0;
            r_lon     <= '0;
            r_alt     <= '0;
            r_time    <= '0;
            r_sats    <= '0;
            r_mask    <= '0;
            r_malf    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_acc     <= n_acc;
            r_cnt     <= n_cnt;
            r_field   <= n_field;
            r_skip    <= n_skip;
            r_lat     <= n_lat;
            r_lon     <= n_lon;
            r_alt     <= n_alt;
            r_time    <= n_time;
            r_sats    <= n_sats;
            r_mask    <= n_mask;
            r_malf    <= n_malf;
            r_out_vld <= n_out_vld;
        end
    end

    // Result payload needs no reset; it is qualified by r_out_vld.
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule

### tb/position_fix_checker.sv
`timescale 1ns / 1ps

module position_fix_checker
    import ppp_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_msg_valid,
    input  logic      i_msg_ready,
    input  t_in_word  i_msg_word,
    input  logic      i_fix_valid,
    input  logic      i_fix_ready,
    input  t_out_word i_fix_word,
    output int        o_errors,
    output int        o_waiting,
    output int        o_fix_count,
    output int        o_malformed_count,
    output int        o_no_lat_count
);

    // Decoder state, mirrors the block.
    t_phase                phase;
    logic [63:0]           acc;
    logic [3:0]            nbytes;
    logic [FIELD_BITS-1:0] fld;
    logic [2:0]            wtype;
    logic [31:0]           skip_left;
    logic [31:0]           lat_h, lon_h, alt_h, time_h, sats_h;
    logic [4:0]            seen;
    logic                  malf;

    t_out_word             fix_expected[$];

    function void restart_msg();
        phase     = PH_TAG;
        acc       = '0;
        nbytes    = '0;
        fld       = '0;
        wtype     = '0;
        skip_left = '0;
        lat_h     = '0;
        lon_h     = '0;
        alt_h     = '0;
        time_h    = '0;
        sats_h    = '0;
        seen      = '0;
        malf      = 1'b0;
    endfunction

    function void mark_malformed();
        malf  = 1'b1;
        phase = PH_DISCARD;
    endfunction

    function void next_field();
        phase  = PH_TAG;
        acc    = '0;
        nbytes = '0;
    endfunction

    // Tag complete: split into field number and wire type.
    function void open_value();
        fld    = acc[31:3];
        wtype  = acc[2:0];
        acc    = '0;
        nbytes = '0;
        case (wtype)
            WT_VARINT:  phase = PH_VARINT;
            WT_LENGTH:  phase = PH_LENGTH;
            WT_FIXED32: phase = PH_FIXED;
            WT_FIXED64: begin
                phase     = PH_SKIP;
                skip_left = FIXED64_BYTES;
            end
            default:    mark_malformed();
        endcase
    endfunction

    function void keep_varint();
        if (fld == FLD_ALTITUDE) begin
            alt_h        = acc[31:0];
            seen[PM_ALT] = 1'b1;
        end else if (fld == FLD_SATELLITES) begin
            sats_h        = acc[31:0];
            seen[PM_SATS] = 1'b1;
        end
    endfunction

    function void parse_position_byte(input t_in_word w);
        logic [6:0] low7;
        logic       more;
        t_out_word  fx;
        low7 = w.message_byte[6:0];
        more = w.message_byte[7];
        case (phase)
            PH_TAG, PH_LENGTH: begin
                acc    = acc | ({57'd0, low7} << (7 * nbytes[2:0]));
                nbytes = nbytes + 1'b1;
                if (!more) begin
                    if (phase == PH_TAG) begin
                        open_value();
                    end else if ({32'd0, acc[31:0]} >= (64'd1 << LENGTH_BITS)) begin
                        mark_malformed();
                    end else if (acc[31:0] == 32'd0) begin
                        next_field();
                    end else begin
                        skip_left = acc[31:0];
                        phase     = PH_SKIP;
                    end
                end else if (nbytes >= TAG_MAX_BYTES) begin
                    mark_malformed();
                end
            end
            PH_VARINT: begin
                acc    = acc | ({57'd0, low7} << (7 * (nbytes % 10)));
                nbytes = nbytes + 1'b1;
                if (!more) begin
                    keep_varint();
                    next_field();
                end else if (nbytes >= VALUE_MAX_BYTES) begin
                    mark_malformed();
                end
            end
            PH_FIXED: begin
                acc    = acc | ({56'd0, w.message_byte} << (8 * nbytes[1:0]));
                nbytes = nbytes + 1'b1;
                if (nbytes >= FIXED32_BYTES) begin
                    if (fld == FLD_LATITUDE) begin
                        lat_h        = acc[31:0];
                        seen[PM_LAT] = 1'b1;
                    end else if (fld == FLD_LONGITUDE) begin
                        lon_h        = acc[31:0];
                        seen[PM_LON] = 1'b1;
                    end else if (fld == FLD_TIME) begin
                        time_h        = acc[31:0];
                        seen[PM_TIME] = 1'b1;
                    end
                    next_field();
                end
            end
            PH_SKIP: begin
                if (skip_left != 0) skip_left = skip_left - 1;
                if (skip_left == 0) next_field();
            end
            default: ;
        endcase

        if (w.final_byte) begin
            // settle whatever the last byte left open
            if (phase != PH_DISCARD) begin
                if (phase == PH_TAG && nbytes != 0) open_value();
                case (phase)
                    PH_VARINT: keep_varint();
                    PH_LENGTH: if (acc[31:0] != 32'd0) mark_malformed();
                    PH_SKIP, PH_FIXED: mark_malformed();
                    default: ;
                endcase
            end
            fx.latitude     = lat_h;
            fx.longitude    = lon_h;
            fx.altitude     = alt_h;
            fx.fix_time     = time_h;
            fx.satellites   = sats_h;
            fx.present_mask = seen;
            if (malf)              fx.parse_status = ST_MALFORMED;
            else if (!seen[PM_LAT]) fx.parse_status = ST_NO_LAT;
            else                   fx.parse_status = ST_OK;
            fix_expected.push_back(fx);
            restart_msg();
        end
    endfunction

    function void check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            o_errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_word exp_fix;
        if (!i_rst_n) begin
            restart_msg();
            fix_expected.delete();
            o_errors          = 0;
            o_fix_count       = 0;
            o_malformed_count = 0;
            o_no_lat_count    = 0;
        end else begin
            if (i_msg_valid && i_msg_ready) parse_position_byte(i_msg_word);
            if (i_fix_valid && i_fix_ready) begin
                if (fix_expected.size() == 0) begin
                    $error("position word with none expected: %h", i_fix_word);
                    o_errors++;
                end else begin
                    exp_fix = fix_expected.pop_front();
                    o_fix_count++;
                    if (exp_fix.parse_status == ST_MALFORMED) o_malformed_count++;
                    if (exp_fix.parse_status == ST_NO_LAT) o_no_lat_count++;
                    check_field("latitude", exp_fix.latitude, i_fix_word.latitude);
                    check_field("longitude", exp_fix.longitude, i_fix_word.longitude);
                    check_field("altitude", exp_fix.altitude, i_fix_word.altitude);
                    check_field("fix_time", exp_fix.fix_time, i_fix_word.fix_time);
                    check_field("satellites", exp_fix.satellites, i_fix_word.satellites);
                    check_field("present_mask", {27'd0, exp_fix.present_mask},
                                {27'd0, i_fix_word.present_mask});
                    check_field("parse_status", {30'd0, exp_fix.parse_status},
                                {30'd0, i_fix_word.parse_status});
                end
            end
        end
        o_waiting = fix_expected.size();
    end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb
    import ppp_pkg::*;
();

    localparam int LIMIT_CYCLES = 500000;
    localparam int RANDOM_BYTES = 1500;
    // receiver hold-off used to back the block up into its input
    localparam int LONG_HOLD    = 400;

    // Wire types the block must reject (groups and reserved codes).
    localparam logic [2:0] WT_SGROUP = 3'd3;
    localparam logic [2:0] WT_EGROUP = 3'd4;
    localparam logic [2:0] WT_RSVD6  = 3'd6;
    localparam logic [2:0] WT_RSVD7  = 3'd7;

    // Well-formed field kinds the generator can emit.
    typedef enum int {
        FK_LAT, FK_LON, FK_TIME, FK_ALT, FK_SATS,
        FK_VARINT, FK_BYTES, FK_FIXED64, FK_FIXED32
    } t_field_kind;

    // Ways to break a message after a good prefix.
    typedef enum int {
        BRK_WIRE_TYPE, BRK_LONG_TAG, BRK_LONG_VALUE, BRK_BIG_LENGTH
    } t_break_kind;

    logic clk;
    logic rst_n;

    ppp_stream_if #(.t_payload(t_in_word))  msg_if ();
    ppp_stream_if #(.t_payload(t_out_word)) fix_if ();

    protobuf_position_parser_top #(
        .LENGTH_BITS (LENGTH_BITS_DEF)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_msg   (msg_if),
        .o_fix   (fix_if)
    );

    int chk_errors, chk_waiting, chk_fixes, chk_malformed, chk_no_lat;

    // Checker only watches; all prediction and comparison lives there.
    position_fix_checker #(
        .LENGTH_BITS (LENGTH_BITS_DEF)
    ) chk (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_msg_valid       (msg_if.valid),
        .i_msg_ready       (msg_if.ready),
        .i_msg_word        (msg_if.payload),
        .i_fix_valid       (fix_if.valid),
        .i_fix_ready       (fix_if.ready),
        .i_fix_word        (fix_if.payload),
        .o_errors          (chk_errors),
        .o_waiting         (chk_waiting),
        .o_fix_count       (chk_fixes),
        .o_malformed_count (chk_malformed),
        .o_no_lat_count    (chk_no_lat)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Watchdog: a hung handshake ends the run here.
    int cycle_count = 0;
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Idle draw before each byte or result word, with occasional stretches of back-to-back traffic.
    function automatic int draw_gap(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(10, 60);
            return 0;
        end
        return $urandom_range(0, 19);
    endfunction

    // ------------------------------------------------------------------
    // Message builder. Bytes collect in msg_bytes, the last one gets the
    // final flag when the message is sent.
    // ------------------------------------------------------------------
    logic [7:0] msg_bytes[$];

    // Extremes of a 32-bit payload show up often.
    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [63:0] rand_varint();
        logic [31:0] w;
        w = rand_word();
        case ($urandom_range(0, 5))
            0:       return {57'd0, 7'($urandom_range(0, 127))};
            1:       return {32'd0, w};
            2:       return {$urandom(), $urandom()};
            3:       return ($urandom_range(0, 1) != 0) ? 64'h8000_0000_0000_0000
                                                        : 64'hFFFF_FFFF_FFFF_FFFF;
            default: return {{32{w[31]}}, w};    // int32 as a protobuf encoder sends it
        endcase
    endfunction

    // Half the time the fields of interest; otherwise small, mid-size and 5-byte-tag numbers.
    function automatic logic [FIELD_BITS-1:0] pick_field();
        logic [FIELD_BITS-1:0] f;
        case ($urandom_range(0, 9))
            0:       f = FLD_LATITUDE;
            1:       f = FLD_LONGITUDE;
            2:       f = FLD_ALTITUDE;
            3:       f = FLD_TIME;
            4:       f = FLD_SATELLITES;
            5, 6:    f = FIELD_BITS'($urandom_range(0, 31));
            7:       f = FIELD_BITS'($urandom_range(32, 4095));
            default: f = FIELD_BITS'($urandom_range(32'h0200_0000, 32'h1FFF_FFFF));
        endcase
        return f;
    endfunction

    // Varint, sometimes padded with redundant zero groups up to max_bytes.
    task automatic push_varint(input logic [63:0] v, input int max_bytes);
        logic [63:0] rest;
        int          need;
        int          pad;
        need = 1;
        rest = v >> 7;
        while (rest != 0) begin
            need++;
            rest = rest >> 7;
        end
        pad = 0;
        if (need < max_bytes && $urandom_range(0, 7) == 0)
            pad = $urandom_range(1, max_bytes - need);
        rest = v;
        while (rest > 64'd127) begin
            msg_bytes.push_back({1'b1, rest[6:0]});
            rest = rest >> 7;
        end
        if (pad == 0) begin
            msg_bytes.push_back({1'b0, rest[6:0]});
        end else begin
            msg_bytes.push_back({1'b1, rest[6:0]});
            repeat (pad - 1) msg_bytes.push_back(8'h80);
            msg_bytes.push_back(8'h00);
        end
    endtask

    task automatic push_tag(input logic [FIELD_BITS-1:0] f, input logic [2:0] wt);
        push_varint({32'd0, f, wt}, int'(TAG_MAX_BYTES));
    endtask

    task automatic push_word(input logic [31:0] v);
        msg_bytes.push_back(v[7:0]);
        msg_bytes.push_back(v[15:8]);
        msg_bytes.push_back(v[23:16]);
        msg_bytes.push_back(v[31:24]);
    endtask

    task automatic push_random(input int n);
        repeat (n) msg_bytes.push_back(8'($urandom()));
    endtask

    task automatic push_field(input t_field_kind kind);
        int len;
        case (kind)
            FK_LAT: begin
                push_tag(FLD_LATITUDE, WT_FIXED32);
                push_word(rand_word());
            end
            FK_LON: begin
                push_tag(FLD_LONGITUDE, WT_FIXED32);
                push_word(rand_word());
            end
            FK_TIME: begin
                push_tag(FLD_TIME, WT_FIXED32);
                push_word(rand_word());
            end
            FK_ALT: begin
                push_tag(FLD_ALTITUDE, WT_VARINT);
                push_varint(rand_varint(), int'(VALUE_MAX_BYTES));
            end
            FK_SATS: begin
                push_tag(FLD_SATELLITES, WT_VARINT);
                push_varint(rand_varint(), int'(VALUE_MAX_BYTES));
            end
            FK_VARINT: begin
                push_tag(pick_field(), WT_VARINT);
                push_varint(rand_varint(), int'(VALUE_MAX_BYTES));
            end
            FK_BYTES: begin
                // an odd long body exercises multi-byte lengths
                len = ($urandom_range(0, 15) == 0) ? $urandom_range(128, 300)
                                                   : $urandom_range(0, 12);
                push_tag(pick_field(), WT_LENGTH);
                push_varint(64'(len), int'(TAG_MAX_BYTES));
                push_random(len);
            end
            FK_FIXED64: begin
                push_tag(pick_field(), WT_FIXED64);
                push_random(FIXED64_BYTES);
            end
            default: begin
                push_tag(pick_field(), WT_FIXED32);
                push_word(rand_word());
            end
        endcase
    endtask

    task automatic push_good_fields();
        if ($urandom_range(0, 1) != 0) push_field(FK_LAT);
        repeat ($urandom_range(1, 6)) push_field(t_field_kind'($urandom_range(0, 8)));
    endtask

    task automatic push_breakage(input t_break_kind kind);
        logic [63:0] len;
        logic [2:0]  wt;
        case (kind)
            BRK_WIRE_TYPE: begin
                case ($urandom_range(0, 3))
                    0:       wt = WT_SGROUP;
                    1:       wt = WT_EGROUP;
                    2:       wt = WT_RSVD6;
                    default: wt = WT_RSVD7;
                endcase
                push_tag(pick_field(), wt);
            end
            BRK_LONG_TAG: begin
                repeat (TAG_MAX_BYTES) msg_bytes.push_back(8'h80 | 8'($urandom_range(0, 127)));
            end
            BRK_LONG_VALUE: begin
                push_tag(($urandom_range(0, 1) != 0) ? FLD_ALTITUDE : pick_field(), WT_VARINT);
                repeat (VALUE_MAX_BYTES)
                    msg_bytes.push_back(8'h80 | 8'($urandom_range(0, 127)));
            end
            default: begin
                // lengths past the skip counter; bits 32 and above are dropped by the block
                len        = {32'd0, $urandom_range(32'h0001_0000, 32'hFFFF_FFFF)};
                len[34:32] = 3'($urandom_range(0, 7));
                push_tag(pick_field(), WT_LENGTH);
                push_varint(len, int'(TAG_MAX_BYTES));
            end
        endcase
        // trailing bytes that the block must swallow
        push_random($urandom_range(0, 6));
    endtask

    task automatic build_random_message();
        int shape;
        int keep;
        shape = $urandom_range(0, 99);
        if (shape < 65) begin
            push_good_fields();
        end else if (shape < 80) begin
            push_good_fields();
            push_breakage(t_break_kind'($urandom_range(0, 3)));
        end else if (shape < 92) begin
            // cut short at any byte: mid-tag, mid-length, mid-body
            push_good_fields();
            keep = $urandom_range(1, msg_bytes.size());
            while (msg_bytes.size() > keep) void'(msg_bytes.pop_back());
        end else begin
            push_random($urandom_range(1, 12));
        end
    endtask

    // ------------------------------------------------------------------
    // Byte sender. Drives at the falling edge, sees the handshake at the rising.
    // ------------------------------------------------------------------
    int tx_calm     = 0;
    int bytes_sent  = 0;
    int msgs_sent   = 0;

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = draw_gap(tx_calm);
        if (gap > 0) begin
            msg_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        msg_if.payload <= {b, last};
        msg_if.valid   <= 1'b1;
        do @(posedge clk); while (!msg_if.ready);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_message();
        foreach (msg_bytes[i]) send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
        msg_bytes.delete();
        msgs_sent++;
    endtask

    // ------------------------------------------------------------------
    // Result receiver: random stalls per word, plus two long hold-offs so the
    // result register fills and the block has to stall the byte stream.
    // ------------------------------------------------------------------
    int rx_calm = 0;
    int taken   = 0;

    initial begin
        int gap;
        fix_if.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            gap = draw_gap(rx_calm);
            if (taken == 10 || taken == 30) gap = LONG_HOLD;
            if (gap > 0) begin
                fix_if.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            fix_if.ready <= 1'b1;
            do @(posedge clk); while (!(fix_if.valid && fix_if.ready));
            taken++;
            @(negedge clk);
        end
    end

    // ------------------------------------------------------------------
    // Main sequence: reset, directed messages, random messages, drain, verdict.
    // ------------------------------------------------------------------
    initial begin
        msg_if.valid   = 1'b0;
        msg_if.payload = '0;
        rst_n          = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Latitude at its most negative value, all else absent.
        push_tag(FLD_LATITUDE, WT_FIXED32);
        push_word(32'h8000_0000);
        send_message();

        // Altitude tag whose continuation bit is set on the final byte:
        // decoded from partial bits, value taken as zero.
        msg_bytes.push_back(8'h80 | {1'b0, FLD_ALTITUDE[3:0], WT_VARINT});
        send_message();

        // Reserved wire type.
        push_tag(FLD_ALTITUDE, WT_RSVD7);
        send_message();

        // Tag still continuing on its fifth byte.
        repeat (TAG_MAX_BYTES) msg_bytes.push_back(8'h80);
        send_message();

        // Length the skip counter cannot hold.
        push_tag(FLD_TIME, WT_LENGTH);
        msg_bytes.push_back(8'h80);
        msg_bytes.push_back(8'h80);
        msg_bytes.push_back(8'h04);
        send_message();

        // Fixed32 body cut short by the final byte.
        push_tag(FLD_LONGITUDE, WT_FIXED32);
        msg_bytes.push_back(8'hFF);
        send_message();

        // Satellites varint cut off: keeps the partial value.
        push_tag(FLD_SATELLITES, WT_VARINT);
        msg_bytes.push_back(8'h85);
        send_message();

        // Value varint still continuing on its tenth byte.
        push_tag(FLD_ALTITUDE, WT_VARINT);
        repeat (VALUE_MAX_BYTES) msg_bytes.push_back(8'hFF);
        send_message();

        while (bytes_sent < RANDOM_BYTES) begin
            build_random_message();
            send_message();
        end
        msg_if.valid <= 1'b0;

        // Drain: every predicted word must come out, then a short settle.
        while (chk_waiting != 0) @(negedge clk);
        repeat (8) @(negedge clk);

        $display("Covered %0d messages / %0d bytes under random stalls and two long holds.",
                 msgs_sent, bytes_sent);
        $display("Checked %0d position words: %0d malformed, %0d without latitude.",
                 chk_fixes, chk_malformed, chk_no_lat);
        if (chk_errors == 0 && chk_waiting == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### protobuf_position_parser_top.f
hdl/ppp_pkg.sv
hdl/ppp_stream_if.sv
hdl/protobuf_position_parser_top.sv
tb/position_fix_checker.sv
tb/tb.sv
